FILE: rtl/ntc_pkg.sv
// shared types, constants and codes for the ntc thermistor filter and table lookup
package ntc_pkg;

    localparam int FILTER_TAPS = 8;
    localparam int TABLE_DEPTH = 64;

    localparam int TAP_BITS = $clog2(FILTER_TAPS);
    localparam int TBL_AW   = $clog2(TABLE_DEPTH);
    localparam int SIZE_W   = $clog2(TABLE_DEPTH + 1);

    localparam int ADC_W  = 12;
    localparam int STEP_W = 10;
    localparam int TEMP_W = 16;
    localparam int ERR_W  = 4;
    localparam int ACC_W  = ADC_W + TAP_BITS;

    localparam logic [ERR_W-1:0]  ERR_LIMIT  = ERR_W'(10);
    localparam logic [TEMP_W-1:0] START_TEMP = TEMP_W'(30);

    localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = SIZE_W'(64);
    localparam logic [STEP_W-1:0] TEMP_STEP_RST  = STEP_W'(1);
    localparam logic [ADC_W-1:0]  FAULT_HIGH_RST = ADC_W'(4095);
    localparam logic [ADC_W-1:0]  FAULT_LOW_RST  = ADC_W'(0);

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_TABLE  = 2'd1,
        CMD_SET    = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_TABLE_SIZE = 2'd0,
        CFG_TEMP_STEP  = 2'd1,
        CFG_FAULT_HIGH = 2'd2,
        CFG_FAULT_LOW  = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LO,
        ST_HI,
        ST_FLO,
        ST_FHI,
        ST_SUM,
        ST_SCAN,
        ST_MUL,
        ST_DONE
    } state_t;

    typedef enum logic {
        ALU_CMP,
        ALU_ADD
    } alu_op_t;

    typedef struct packed {
        alu_op_t            op;
        logic [ACC_W-1:0]   a;
        logic [ADC_W-1:0]   b;
    } alu_req_t;

    typedef struct packed {
        logic [ACC_W-1:0]   sum;
        logic               lt;
        logic               eq;
    } alu_res_t;

endpackage

FILE: rtl/ntc_ram.sv
// generic single write port ram with one registered read port
module ntc_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/ntc_alu.sv
// shared add and compare unit: one adder serves both the ring sum and every compare
module ntc_alu (
    input  ntc_pkg::alu_req_t req,
    output ntc_pkg::alu_res_t res
);

    localparam int W = ntc_pkg::ACC_W + 1;

    logic          sub;
    logic [W-1:0]  bx;
    logic [W:0]    tot;

    always_comb
    begin
        sub = (req.op == ntc_pkg::ALU_CMP);
        bx  = W'(req.b);
        // a - b as a + ~b + 1, carry out set when a >= b
        tot = {2'b00, req.a} + {1'b0, (sub ? ~bx : bx)} + (W + 1)'(sub);
        res.sum = tot[ntc_pkg::ACC_W-1:0];
        res.lt  = ~tot[W];
        res.eq  = (tot[W-1:0] == '0);
    end

endmodule

FILE: rtl/ntc_adc_filter_table_lookup.sv
// top level: ntc thermistor channel with moving average and calibration table lookup
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------------------
//  in       | in_valid/in_stall  | cmd, adc_sample, table_index, table_value,
//           |                    | set_value
//  out      | out_valid/out_stall| temperature, error_flag, sample_accepted,
//           |                    | temp_updated
//  cfg      | cfg_we             | cfg_index, cfg_data
//
// a full sample request runs two compares against the table ends, one add per ring
//   entry and one compare per table entry, all through the one shared add/compare
//   unit, and reads the table through the registered ram port
// table writes, overrides and the unused code go straight to done; warm-up samples end
// after the range checks, rejects after the fault checks unless the error count clears
// in_stall is high from acceptance until the result is loaded into the output register
// a stalled result holds the block in its done state until the output register frees up
// reset clears all control state, the ring, the counters and sets the temperature to 30
module ntc_adc_filter_table_lookup (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [11:0] adc_sample,
    input  logic [5:0]  table_index,
    input  logic [11:0] table_value,
    input  logic [15:0] set_value,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] temperature,
    output logic        error_flag,
    output logic        sample_accepted,
    output logic        temp_updated,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    localparam int TAPS    = ntc_pkg::FILTER_TAPS;
    localparam int TAP_B   = ntc_pkg::TAP_BITS;
    localparam int TBL_AW  = ntc_pkg::TBL_AW;
    localparam int SIZE_W  = ntc_pkg::SIZE_W;
    localparam int ADC_W   = ntc_pkg::ADC_W;
    localparam int STEP_W  = ntc_pkg::STEP_W;
    localparam int TEMP_W  = ntc_pkg::TEMP_W;
    localparam int ERR_W   = ntc_pkg::ERR_W;
    localparam int ACC_W   = ntc_pkg::ACC_W;
    localparam int TABLE_DEPTH_C = ntc_pkg::TABLE_DEPTH;

    // configuration registers
    logic [SIZE_W-1:0] table_size_reg;
    logic [STEP_W-1:0] temp_step_reg;
    logic [ADC_W-1:0]  fault_high_reg;
    logic [ADC_W-1:0]  fault_low_reg;

    // architectural state
    logic [ADC_W-1:0]  sample_ring_reg [TAPS];
    logic [TAP_B-1:0]  ring_pos_reg, ring_pos_next;
    logic [ERR_W-1:0]  warm_cnt_reg, warm_cnt_next;
    logic [ERR_W-1:0]  err_cnt_reg, err_cnt_next;
    logic              fault_flag_reg, fault_flag_next;
    logic [TEMP_W-1:0] cur_temp_reg, cur_temp_next;

    // sequencer state and working registers
    ntc_pkg::state_t   state_reg, state_next;
    logic [ADC_W-1:0]  samp_reg, samp_next;
    logic              lo_ok_reg, lo_ok_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [ADC_W-1:0]  avg_reg, avg_next;
    logic [TAP_B-1:0]  tap_reg, tap_next;
    logic [TBL_AW-1:0] idx_reg, idx_next;
    logic              ge_prev_reg, ge_prev_next;
    logic              found_reg, found_next;
    logic [TBL_AW-1:0] best_reg, best_next;
    logic              acc_flag_reg, acc_flag_next;
    logic              upd_flag_reg, upd_flag_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [TEMP_W-1:0] out_temp_reg, out_temp_next;
    logic              out_err_reg, out_err_next;
    logic              out_acc_reg, out_acc_next;
    logic              out_upd_reg, out_upd_next;

    // shared unit, table ram and helpers
    ntc_pkg::alu_req_t alu_req;
    ntc_pkg::alu_res_t alu_res;
    logic              in_take;
    logic              ring_we;
    logic              tbl_we;
    logic [TBL_AW-1:0] tbl_raddr;
    logic [ADC_W-1:0]  tbl_rdata;
    logic [SIZE_W-1:0] n_used;
    logic [TBL_AW-1:0] last_idx;
    logic              slot_free;
    logic [TEMP_W-1:0] prod;

    assign in_stall  = (state_reg != ntc_pkg::ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign ring_we   = in_take && (cmd == ntc_pkg::CMD_SAMPLE);
    assign tbl_we    = in_take && (cmd == ntc_pkg::CMD_TABLE);

    // table size clamped to the usable range
    always_comb
    begin
        if (table_size_reg < SIZE_W'(2))
        begin
            n_used = SIZE_W'(2);
        end
        else if (table_size_reg > SIZE_W'(TABLE_DEPTH_C))
        begin
            n_used = SIZE_W'(TABLE_DEPTH_C);
        end
        else
        begin
            n_used = table_size_reg;
        end
        last_idx = TBL_AW'(n_used - SIZE_W'(1));
    end

    // calibration table
    ntc_ram #(
        .WIDTH (ADC_W),
        .DEPTH (TABLE_DEPTH_C)
    ) u_cal_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (table_index),
        .wdata (table_value),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    ntc_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    // table read address: first entry while idle or summing, last entry for the
    // upper range check, next entry during the scan
    always_comb
    begin
        unique case (state_reg)
            ntc_pkg::ST_LO:   tbl_raddr = last_idx;
            ntc_pkg::ST_SCAN: tbl_raddr = idx_reg + TBL_AW'(1);
            default:          tbl_raddr = '0;
        endcase
    end

    // operand selection for the shared unit
    always_comb
    begin
        alu_req.op = ntc_pkg::ALU_CMP;
        alu_req.a  = ACC_W'(samp_reg);
        alu_req.b  = tbl_rdata;
        unique case (state_reg)
            ntc_pkg::ST_FLO:  alu_req.b = fault_low_reg;
            ntc_pkg::ST_FHI:  alu_req.b = fault_high_reg;
            ntc_pkg::ST_SUM:
            begin
                alu_req.op = ntc_pkg::ALU_ADD;
                alu_req.a  = acc_reg;
                alu_req.b  = sample_ring_reg[tap_reg];
            end
            ntc_pkg::ST_SCAN: alu_req.a = ACC_W'(avg_reg);
            default:          alu_req.a = ACC_W'(samp_reg);
        endcase
    end

    assign prod = TEMP_W'(best_reg) * TEMP_W'(temp_step_reg);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        samp_next       = samp_reg;
        lo_ok_next      = lo_ok_reg;
        acc_next        = acc_reg;
        avg_next        = avg_reg;
        tap_next        = tap_reg;
        idx_next        = idx_reg;
        ge_prev_next    = ge_prev_reg;
        found_next      = found_reg;
        best_next       = best_reg;
        acc_flag_next   = acc_flag_reg;
        upd_flag_next   = upd_flag_reg;
        ring_pos_next   = ring_pos_reg;
        warm_cnt_next   = warm_cnt_reg;
        err_cnt_next    = err_cnt_reg;
        fault_flag_next = fault_flag_reg;
        cur_temp_next   = cur_temp_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_temp_next   = out_temp_reg;
        out_err_next    = out_err_reg;
        out_acc_next    = out_acc_reg;
        out_upd_next    = out_upd_reg;

        unique case (state_reg)
            ntc_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    samp_next     = adc_sample;
                    acc_flag_next = 1'b0;
                    upd_flag_next = 1'b0;
                    if (cmd == ntc_pkg::CMD_SAMPLE)
                    begin
                        state_next = ntc_pkg::ST_LO;
                    end
                    else
                    begin
                        if (cmd == ntc_pkg::CMD_SET)
                        begin
                            cur_temp_next = set_value;
                        end
                        state_next = ntc_pkg::ST_DONE;
                    end
                end
            end
            ntc_pkg::ST_LO:
            begin
                // sample at or above the first entry
                lo_ok_next = !alu_res.lt;
                state_next = ntc_pkg::ST_HI;
            end
            ntc_pkg::ST_HI:
            begin
                if (lo_ok_reg && (alu_res.lt || alu_res.eq) && (err_cnt_reg < ntc_pkg::ERR_LIMIT))
                begin
                    acc_flag_next = 1'b1;
                    if (ring_pos_reg == TAP_B'(TAPS - 1))
                    begin
                        ring_pos_next = '0;
                    end
                    else
                    begin
                        ring_pos_next = ring_pos_reg + TAP_B'(1);
                    end
                    if (warm_cnt_reg < ERR_W'(TAPS))
                    begin
                        warm_cnt_next = warm_cnt_reg + ERR_W'(1);
                        state_next    = ntc_pkg::ST_DONE;
                    end
                    else
                    begin
                        acc_next   = '0;
                        tap_next   = '0;
                        state_next = ntc_pkg::ST_SUM;
                    end
                end
                else if (err_cnt_reg > ntc_pkg::ERR_LIMIT)
                begin
                    err_cnt_next    = '0;
                    fault_flag_next = 1'b1;
                    state_next      = ntc_pkg::ST_DONE;
                end
                else
                begin
                    state_next = ntc_pkg::ST_FLO;
                end
            end
            ntc_pkg::ST_FLO:
            begin
                // reuse lo_ok as the below-fault-low mark
                lo_ok_next = alu_res.lt;
                state_next = ntc_pkg::ST_FHI;
            end
            ntc_pkg::ST_FHI:
            begin
                if (lo_ok_reg || (!alu_res.lt && !alu_res.eq))
                begin
                    err_cnt_next = err_cnt_reg + ERR_W'(1);
                end
                state_next = ntc_pkg::ST_DONE;
            end
            ntc_pkg::ST_SUM:
            begin
                acc_next = alu_res.sum;
                if (tap_reg == TAP_B'(TAPS - 1))
                begin
                    avg_next     = alu_res.sum[ACC_W-1:TAP_B];
                    idx_next     = '0;
                    ge_prev_next = 1'b0;
                    found_next   = 1'b0;
                    state_next   = ntc_pkg::ST_SCAN;
                end
                else
                begin
                    tap_next = tap_reg + TAP_B'(1);
                end
            end
            ntc_pkg::ST_SCAN:
            begin
                // pair (idx-1, idx) brackets the average; the last hit wins
                if ((idx_reg != '0) && ge_prev_reg && (alu_res.lt || alu_res.eq))
                begin
                    found_next = 1'b1;
                    best_next  = idx_reg - TBL_AW'(1);
                end
                ge_prev_next = !alu_res.lt;
                if (idx_reg == last_idx)
                begin
                    state_next = ntc_pkg::ST_MUL;
                end
                else
                begin
                    idx_next = idx_reg + TBL_AW'(1);
                end
            end
            ntc_pkg::ST_MUL:
            begin
                upd_flag_next = 1'b1;
                err_cnt_next  = '0;
                if (found_reg)
                begin
                    cur_temp_next = prod;
                end
                state_next = ntc_pkg::ST_DONE;
            end
            ntc_pkg::ST_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_temp_next  = cur_temp_reg;
                    out_err_next   = fault_flag_reg;
                    out_acc_next   = acc_flag_reg;
                    out_upd_next   = upd_flag_reg;
                    state_next     = ntc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ntc_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ntc_pkg::ST_IDLE;
            ring_pos_reg   <= '0;
            warm_cnt_reg   <= '0;
            err_cnt_reg    <= '0;
            fault_flag_reg <= 1'b0;
            cur_temp_reg   <= ntc_pkg::START_TEMP;
            out_valid_reg  <= 1'b0;
            table_size_reg <= ntc_pkg::TABLE_SIZE_RST;
            temp_step_reg  <= ntc_pkg::TEMP_STEP_RST;
            fault_high_reg <= ntc_pkg::FAULT_HIGH_RST;
            fault_low_reg  <= ntc_pkg::FAULT_LOW_RST;
            for (int i = 0; i < TAPS; i++)
            begin
                sample_ring_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            ring_pos_reg   <= ring_pos_next;
            warm_cnt_reg   <= warm_cnt_next;
            err_cnt_reg    <= err_cnt_next;
            fault_flag_reg <= fault_flag_next;
            cur_temp_reg   <= cur_temp_next;
            out_valid_reg  <= out_valid_next;
            // every sample lands in the current slot, even a rejected one
            if (ring_we)
            begin
                sample_ring_reg[ring_pos_reg] <= adc_sample;
            end
            if (cfg_we)
            begin
                unique case (ntc_pkg::cfg_idx_t'(cfg_index))
                    ntc_pkg::CFG_TABLE_SIZE: table_size_reg <= cfg_data[SIZE_W-1:0];
                    ntc_pkg::CFG_TEMP_STEP:  temp_step_reg  <= cfg_data[STEP_W-1:0];
                    ntc_pkg::CFG_FAULT_HIGH: fault_high_reg <= cfg_data;
                    ntc_pkg::CFG_FAULT_LOW:  fault_low_reg  <= cfg_data;
                    default:                 fault_low_reg  <= fault_low_reg;
                endcase
            end
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        samp_reg     <= samp_next;
        lo_ok_reg    <= lo_ok_next;
        acc_reg      <= acc_next;
        avg_reg      <= avg_next;
        tap_reg      <= tap_next;
        idx_reg      <= idx_next;
        ge_prev_reg  <= ge_prev_next;
        found_reg    <= found_next;
        best_reg     <= best_next;
        acc_flag_reg <= acc_flag_next;
        upd_flag_reg <= upd_flag_next;
        out_temp_reg <= out_temp_next;
        out_err_reg  <= out_err_next;
        out_acc_reg  <= out_acc_next;
        out_upd_reg  <= out_upd_next;
    end

    assign out_valid       = out_valid_reg;
    assign temperature     = out_temp_reg;
    assign error_flag      = out_err_reg;
    assign sample_accepted = out_acc_reg;
    assign temp_updated    = out_upd_reg;

    // error count only passes the limit by one before it is cleared
    a_err_bound: assert property (@(posedge clk) disable iff (!rst_n)
        err_cnt_reg <= ntc_pkg::ERR_LIMIT + ERR_W'(1))
        else $error("error count beyond limit");

    // warm-up counter saturates at the ring depth
    a_warm_bound: assert property (@(posedge clk) disable iff (!rst_n)
        warm_cnt_reg <= ERR_W'(TAPS))
        else $error("warm-up count beyond ring depth");

    // a temperature update only reports on an accepted sample
    a_upd_acc: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_upd_reg) |-> out_acc_reg)
        else $error("update without accepted sample");

    // the table scan never runs past the last entry in use
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ntc_pkg::ST_SCAN) |-> (idx_reg <= last_idx))
        else $error("table scan out of range");

    // leaving the done state always presents a result
    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ntc_pkg::ST_DONE) && slot_free) |=> out_valid_reg)
        else $error("result lost on completion");

endmodule
